[rtl/cdq_pkg.sv]
// Shared types and constants of the circular deque with rotate unit.
package cdq_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned KindW   = 3;
  localparam int unsigned StatusW = 2;
  localparam int unsigned SizeW   = 5;

  typedef enum logic [KindW-1:0] {
    K_PUSH_FRONT = 3'd0,
    K_PUSH_BACK  = 3'd1,
    K_POP_FRONT  = 3'd2,
    K_POP_BACK   = 3'd3,
    K_ROT_FWD    = 3'd4,
    K_ROT_BACK   = 3'd5,
    K_CLEAR      = 3'd6,
    K_DUMP       = 3'd7
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    status_e          status;
    logic [SizeW-1:0] size;
    logic [DataW-1:0] front_value;
    logic [DataW-1:0] back_value;
    logic [DataW-1:0] dump_value;
    logic             is_empty;
    logic             is_last;
  } res_t;

endpackage

[rtl/cdq_if.sv]
// Valid/ready channel interfaces for the deque commands and its result items.
interface cdq_in_if import cdq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [KindW-1:0]         kind;
  logic signed [DataW-1:0]  value;

  modport source (output valid, kind, value, input ready);
  modport sink   (input valid, kind, value, output ready);
endinterface

interface cdq_out_if import cdq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [StatusW-1:0]       status;
  logic [SizeW-1:0]         size;
  logic signed [DataW-1:0]  front_value;
  logic signed [DataW-1:0]  back_value;
  logic signed [DataW-1:0]  dump_value;
  logic                     is_empty;
  logic                     is_last;

  modport source (output valid, status, size, front_value, back_value, dump_value,
                  is_empty, is_last, input ready);
  modport sink   (input valid, status, size, front_value, back_value, dump_value,
                  is_empty, is_last, output ready);
endinterface

[rtl/cdq_mem.sv]
// Element store: one write port and one read port with registered read data.
module cdq_mem import cdq_pkg::*; #(
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [DataW-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [DataW-1:0]         rdata_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read data holds its value until the next read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/circular_deque_with_rotate_unit.sv]
// Top level of the circular deque: command decode, ring pointers and result register.
//
// Usage: commands enter on in_i (kind and value) and results leave on out_o, both
// valid/ready channels; an item moves at a clock edge where valid and ready are high.
// Every command yields one result item with status, size, front and back, except a
// dump of a non-empty queue, which yields one item per element from front to back
// with is_last on the final one.
// Sequencing: the elements live in a synchronous memory with registered read data,
// while the front and back elements are also kept in registers. Push, clear, empty
// dump and any refused command need no memory read. Pop and rotate of a queue with
// two or more elements pass through a fetch state that waits for the memory read
// that fetches the new front or back. A dump issues one memory read per element.
// Results are computed combinationally and held in the output register.
// Stalls: the output register holds one result; a new command is still accepted
// while it waits, and the unit parks the next result until the register frees up.
// A dump advances only while its results are taken.
// Reset: the queue is empty with the head at slot zero and no result pending. The
// memory contents are not cleared; only slots that hold elements are ever read.
module circular_deque_with_rotate_unit import cdq_pkg::*; #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cdq_in_if.sink    in_i,
  cdq_out_if.source out_o
);

  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned SumW = CntW + 1;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_FETCH = 4'b0010,
    S_EMIT  = 4'b0100,
    S_DUMP  = 4'b1000
  } state_e;

  // Slot that lies off places after base, modulo the capacity.
  function automatic logic [IdxW-1:0] slot_add(input logic [IdxW-1:0] base,
                                               input logic [CntW-1:0] off);
    logic [SumW-1:0] sum;
    sum = SumW'(base) + SumW'(off);
    if (sum >= SumW'(CAPACITY)) begin
      sum = sum - SumW'(CAPACITY);
    end
    return sum[IdxW-1:0];
  endfunction

  // Builds a result item; front and back read as zero on an empty queue.
  function automatic res_t make_res(input status_e st, input logic [CntW-1:0] cnt,
                                    input logic [DataW-1:0] fr,
                                    input logic [DataW-1:0] bk,
                                    input logic [DataW-1:0] dv, input logic last);
    res_t r;
    r.status      = st;
    r.size        = SizeW'(cnt);
    r.front_value = (cnt == '0) ? '0 : fr;
    r.back_value  = (cnt == '0) ? '0 : bk;
    r.dump_value  = dv;
    r.is_empty    = (cnt == '0);
    r.is_last     = last;
    return r;
  endfunction

  state_e           state_q, state_d;
  logic [IdxW-1:0]  head_q, head_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [CntW-1:0]  idx_q, idx_d;
  logic [DataW-1:0] front_q, front_d;
  logic [DataW-1:0] back_q, back_d;
  status_e          status_q, status_d;
  logic             fetch_front_q, fetch_front_d;
  logic             out_valid_q, out_valid_d;
  res_t             out_q, out_d;

  logic             mem_we, mem_re;
  logic [IdxW-1:0]  mem_waddr, mem_raddr;
  logic [DataW-1:0] mem_wdata, mem_rdata;

  logic             in_acc, out_free, load_out;
  logic             is_empty_now, is_full_now, single;
  logic [IdxW-1:0]  head_prev, head_next, tail_slot, back_prev_slot;
  kind_e            kind;
  status_e          acc_status;
  res_t             res;

  cdq_mem #(
    .Depth (CAPACITY)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign kind           = kind_e'(in_i.kind);
  assign in_i.ready     = (state_q == S_IDLE);
  assign in_acc         = in_i.valid && in_i.ready;
  assign out_free       = !out_valid_q || out_o.ready;
  assign is_empty_now   = (count_q == '0);
  assign is_full_now    = (count_q >= CntW'(CAPACITY));
  assign single         = (count_q == CntW'(1));
  assign head_prev      = (head_q == '0) ? IdxW'(CAPACITY - 1) : head_q - IdxW'(1);
  assign head_next      = slot_add(head_q, CntW'(1));
  assign tail_slot      = slot_add(head_q, count_q);
  // Slot of the element just ahead of the back; used only with two or more elements.
  assign back_prev_slot = slot_add(head_q, count_q - CntW'(2));

  always_comb begin
    state_d       = state_q;
    head_d        = head_q;
    count_d       = count_q;
    idx_d         = idx_q;
    front_d       = front_q;
    back_d        = back_q;
    status_d      = status_q;
    fetch_front_d = fetch_front_q;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = '0;
    mem_re        = 1'b0;
    mem_raddr     = '0;
    acc_status    = ST_OK;
    load_out      = 1'b0;
    res           = out_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          unique case (kind)
            K_PUSH_FRONT: begin
              if (is_full_now) begin
                acc_status = ST_FULL;
              end else begin
                head_d    = head_prev;
                mem_we    = 1'b1;
                mem_waddr = head_prev;
                mem_wdata = in_i.value;
                front_d   = in_i.value;
                if (is_empty_now) begin
                  back_d = in_i.value;
                end
                count_d = count_q + CntW'(1);
              end
            end
            K_PUSH_BACK: begin
              if (is_full_now) begin
                acc_status = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = tail_slot;
                mem_wdata = in_i.value;
                back_d    = in_i.value;
                if (is_empty_now) begin
                  front_d = in_i.value;
                end
                count_d = count_q + CntW'(1);
              end
            end
            K_POP_FRONT: begin
              if (is_empty_now) begin
                acc_status = ST_EMPTY;
              end else begin
                head_d  = head_next;
                count_d = count_q - CntW'(1);
                if (!single) begin
                  mem_re        = 1'b1;
                  mem_raddr     = head_next;
                  fetch_front_d = 1'b1;
                  state_d       = S_FETCH;
                end
              end
            end
            K_POP_BACK: begin
              if (is_empty_now) begin
                acc_status = ST_EMPTY;
              end else begin
                count_d = count_q - CntW'(1);
                if (!single) begin
                  mem_re        = 1'b1;
                  mem_raddr     = back_prev_slot;
                  fetch_front_d = 1'b0;
                  state_d       = S_FETCH;
                end
              end
            end
            K_ROT_FWD: begin
              // The front element is copied behind the back; the slot after the
              // old head becomes the new front.
              if (!is_empty_now) begin
                mem_we    = 1'b1;
                mem_waddr = tail_slot;
                mem_wdata = front_q;
                head_d    = head_next;
                back_d    = front_q;
                if (!single) begin
                  mem_re        = 1'b1;
                  mem_raddr     = head_next;
                  fetch_front_d = 1'b1;
                  state_d       = S_FETCH;
                end
              end
            end
            K_ROT_BACK: begin
              // The back element is copied in front of the head; the element just
              // ahead of the old back becomes the new back.
              if (!is_empty_now) begin
                head_d    = head_prev;
                mem_we    = 1'b1;
                mem_waddr = head_prev;
                mem_wdata = back_q;
                front_d   = back_q;
                if (!single) begin
                  mem_re        = 1'b1;
                  mem_raddr     = back_prev_slot;
                  fetch_front_d = 1'b0;
                  state_d       = S_FETCH;
                end
              end
            end
            K_CLEAR: begin
              head_d  = '0;
              count_d = '0;
            end
            K_DUMP: begin
              if (!is_empty_now) begin
                mem_re    = 1'b1;
                mem_raddr = head_q;
                idx_d     = CntW'(1);
                state_d   = S_DUMP;
              end
            end
            default: begin
              acc_status = ST_OK;
            end
          endcase

          status_d = acc_status;
          // Commands that need no memory read report right away, or park their
          // result when the output register is still occupied.
          if (state_d == S_IDLE) begin
            if (out_free) begin
              load_out = 1'b1;
              res      = make_res(acc_status, count_d, front_d, back_d, '0, 1'b1);
            end else begin
              state_d = S_EMIT;
            end
          end
        end
      end
      S_FETCH: begin
        if (fetch_front_q) begin
          front_d = mem_rdata;
        end else begin
          back_d = mem_rdata;
        end
        if (out_free) begin
          load_out = 1'b1;
          res      = make_res(status_q, count_q, front_d, back_d, '0, 1'b1);
          state_d  = S_IDLE;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          load_out = 1'b1;
          res      = make_res(status_q, count_q, front_q, back_q, '0, 1'b1);
          state_d  = S_IDLE;
        end
      end
      S_DUMP: begin
        // The read data holds element idx_q - 1; the next read goes out only
        // once this element has been handed over.
        if (out_free) begin
          load_out = 1'b1;
          res      = make_res(ST_OK, count_q, front_q, back_q, mem_rdata,
                              idx_q == count_q);
          if (idx_q == count_q) begin
            state_d = S_IDLE;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = slot_add(head_q, idx_q);
            idx_d     = idx_q + CntW'(1);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (load_out) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end else begin
      out_valid_d = out_valid_q && !out_o.ready;
      out_d       = out_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      head_q        <= '0;
      count_q       <= '0;
      idx_q         <= '0;
      status_q      <= ST_OK;
      fetch_front_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      head_q        <= head_d;
      count_q       <= count_d;
      idx_q         <= idx_d;
      status_q      <= status_d;
      fetch_front_q <= fetch_front_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    front_q <= front_d;
    back_q  <= back_d;
    out_q   <= out_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = out_q.status;
  assign out_o.size        = out_q.size;
  assign out_o.front_value = out_q.front_value;
  assign out_o.back_value  = out_q.back_value;
  assign out_o.dump_value  = out_q.dump_value;
  assign out_o.is_empty    = out_q.is_empty;
  assign out_o.is_last     = out_q.is_last;

  // The element count never goes beyond the capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("element count above capacity");

  // A result is never loaded over one that has not been taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> out_free)
    else $error("result register overwritten");

  // A dump walks only over slots that hold elements.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DUMP |-> (idx_q >= CntW'(1)) && (idx_q <= count_q))
    else $error("dump index out of range");

  // The cycle after a memory fetch either reports or parks the result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FETCH |=> (state_q == S_IDLE) || (state_q == S_EMIT))
    else $error("fetch state not left");

  // A refused push leaves the element count untouched.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && is_full_now && ((kind == K_PUSH_FRONT) || (kind == K_PUSH_BACK))
    |=> count_q == $past(count_q))
    else $error("refused push changed the count");

endmodule

[bench/tb_circular_deque_with_rotate_unit.sv]
// Self-checking testbench for the circular deque with rotate unit.
`timescale 1ns / 1ps

module tb_circular_deque_with_rotate_unit;
  import cdq_pkg::*;

  // Bench constants. The deque depth matches the parameter that the block is built with.
  localparam int unsigned DEPTH          = 16;
  localparam int unsigned CLK_PERIOD     = 10;
  localparam int unsigned RESET_CYCLES   = 10;
  localparam int unsigned RANDOM_ITEMS   = 388;
  localparam int unsigned HOLD_AT_ITEM   = 150;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned MAX_GAP        = 17;
  localparam int unsigned DRAIN_CYCLES   = 40;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned MAX_REPORTS    = 10;

  // Traffic shapes of the random part: mostly filling, mostly draining, or balanced.
  typedef enum int {FILL_PHASE, DRAIN_PHASE, MIXED_PHASE} phase_e;

  // Holds a private copy of the ring and the list of result items it still owes.
  class deque_scoreboard;
    logic [DataW-1:0] ring_slots [DEPTH];
    int unsigned      head_ptr;
    int unsigned      fill_count;
    res_t             expected_results [$];
    int unsigned      fail_count;

    function new();
      head_ptr   = 0;
      fill_count = 0;
      fail_count = 0;
    endfunction

    function int unsigned slot(int unsigned offset);
      return (head_ptr + offset) % DEPTH;
    endfunction

    // Front and back are read from the ring as it stands when the item is queued.
    function void add_result(status_e st, logic [DataW-1:0] dump_val, logic last);
      res_t r;
      r.status      = st;
      r.size        = fill_count[SizeW-1:0];
      r.front_value = (fill_count != 0) ? ring_slots[slot(0)] : '0;
      r.back_value  = (fill_count != 0) ? ring_slots[slot(fill_count - 1)] : '0;
      r.dump_value  = dump_val;
      r.is_empty    = (fill_count == 0);
      r.is_last     = last;
      expected_results.push_back(r);
    endfunction

    // Applies one accepted command to the ring and queues the result items it causes.
    function void note_command(kind_e kind, logic [DataW-1:0] value);
      status_e st;
      st = ST_OK;
      case (kind)
        K_PUSH_FRONT: begin
          if (fill_count >= DEPTH) begin
            st = ST_FULL;
          end else begin
            head_ptr = (head_ptr + DEPTH - 1) % DEPTH;
            ring_slots[head_ptr] = value;
            fill_count++;
          end
        end
        K_PUSH_BACK: begin
          if (fill_count >= DEPTH) begin
            st = ST_FULL;
          end else begin
            ring_slots[slot(fill_count)] = value;
            fill_count++;
          end
        end
        K_POP_FRONT: begin
          if (fill_count == 0) begin
            st = ST_EMPTY;
          end else begin
            head_ptr = slot(1);
            fill_count--;
          end
        end
        K_POP_BACK: begin
          if (fill_count == 0) st = ST_EMPTY;
          else fill_count--;
        end
        K_ROT_FWD: begin
          if (fill_count != 0) begin
            ring_slots[slot(fill_count)] = ring_slots[head_ptr];
            head_ptr = slot(1);
          end
        end
        K_ROT_BACK: begin
          if (fill_count != 0) begin
            head_ptr = (head_ptr + DEPTH - 1) % DEPTH;
            ring_slots[head_ptr] = ring_slots[slot(fill_count)];
          end
        end
        K_CLEAR: begin
          head_ptr   = 0;
          fill_count = 0;
        end
        default: begin
          if (fill_count == 0) begin
            add_result(ST_OK, '0, 1'b1);
          end else begin
            for (int unsigned i = 0; i < fill_count; i++) begin
              add_result(ST_OK, ring_slots[slot(i)], (i + 1 == fill_count));
            end
          end
          return;
        end
      endcase
      add_result(st, '0, 1'b1);
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction

    // Compares one result item against the oldest expectation, field by field.
    function void check_result(res_t got);
      res_t exp;
      if (expected_results.size() == 0) begin
        if (fail_count < MAX_REPORTS) begin
          $display("[%0t] unexpected result item: status=%0d size=%0d dump=%h last=%0b",
                   $realtime, got.status, got.size, got.dump_value, got.is_last);
        end
        fail_count++;
        return;
      end
      exp = expected_results.pop_front();
      if (got.status      !== exp.status      || got.size       !== exp.size       ||
          got.front_value !== exp.front_value || got.back_value !== exp.back_value ||
          got.dump_value  !== exp.dump_value  || got.is_empty   !== exp.is_empty   ||
          got.is_last     !== exp.is_last) begin
        if (fail_count < MAX_REPORTS) begin
          $display("[%0t] result mismatch", $realtime);
          $display("  expected: status=%0d size=%0d front=%h back=%h dump=%h empty=%0b last=%0b",
                   exp.status, exp.size, exp.front_value, exp.back_value,
                   exp.dump_value, exp.is_empty, exp.is_last);
          $display("  actual:   status=%0d size=%0d front=%h back=%h dump=%h empty=%0b last=%0b",
                   got.status, got.size, got.front_value, got.back_value,
                   got.dump_value, got.is_empty, got.is_last);
        end
        fail_count++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  cdq_in_if  cmd_if ();
  cdq_out_if res_if ();

  circular_deque_with_rotate_unit #(
    .CAPACITY (DEPTH)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_if),
    .out_o  (res_if)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  deque_scoreboard sb = new();

  // Handshake between the command driver and the result taker for the one long stall.
  // The driver raises hold_req partway through the run; the taker then keeps ready low
  // for HOLD_CYCLES while the driver offers items back to back, so the block fills
  // its result register and its parking slot and must drop ready on the command side.
  bit hold_req    = 1'b0;
  bit hold_active = 1'b0;

  // Both sides switch now and then into a stretch with no idle cycles at all, so that
  // back-to-back traffic is seen as well as gaps falling on every phase of the block.
  bit send_burst = 1'b0;
  bit take_burst = 1'b0;

  function automatic int unsigned draw_gap(bit burst);
    return burst ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  // Values favor the extremes and the sign boundary, with plain random words in between.
  function automatic logic [DataW-1:0] draw_value();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // Picks the next command for the current phase. Clear is kept rare so that the
  // fill phases actually reach a full deque and the drain phases an empty one.
  function automatic kind_e pick_kind(phase_e phase);
    int unsigned r;
    int unsigned push_pct;
    r = $urandom_range(0, 99);
    if (r < 2) return K_CLEAR;
    if (r < 10) return K_DUMP;
    if (r < 22) return $urandom_range(0, 1) ? K_ROT_FWD : K_ROT_BACK;
    case (phase)
      FILL_PHASE:  push_pct = 75;
      DRAIN_PHASE: push_pct = 25;
      default:     push_pct = 50;
    endcase
    if ($urandom_range(0, 99) < push_pct) begin
      return $urandom_range(0, 1) ? K_PUSH_FRONT : K_PUSH_BACK;
    end
    return $urandom_range(0, 1) ? K_POP_FRONT : K_POP_BACK;
  endfunction

  // Offers one command and returns once it is accepted. Valid gets exactly one
  // nonblocking write per edge: it is lowered only when an idle gap follows, so a
  // zero gap leaves it high across consecutive items.
  task automatic send_cmd(kind_e kind, logic [DataW-1:0] value);
    int unsigned gap;
    gap = hold_active ? 0 : draw_gap(send_burst);
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.kind  <= kind;
    cmd_if.value <= value;
    do @(posedge clk_i); while (!cmd_if.ready);
    // Ready is sampled before the edge updates land, so this is the accepting edge.
    sb.note_command(kind, value);
    if ($urandom_range(0, 29) == 0) send_burst = ~send_burst;
  endtask

  // Command side: reset, a directed opening, then phased random traffic.
  initial begin : command_driver
    phase_e      phase;
    int unsigned phase_left;
    cmd_if.valid <= 1'b0;
    cmd_if.kind  <= K_PUSH_FRONT;
    cmd_if.value <= '0;
    rst_ni       <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed opening: value extremes in both push directions, rotations both ways,
    // a dump of a populated deque, pops down to empty, then every refused or no-op
    // case on the empty deque, a dump of the empty deque, and clear.
    send_cmd(K_PUSH_BACK,  32'h8000_0000);
    send_cmd(K_PUSH_FRONT, 32'h7fff_ffff);
    send_cmd(K_PUSH_BACK,  32'hffff_ffff);
    send_cmd(K_PUSH_FRONT, 32'h0000_0000);
    send_cmd(K_PUSH_BACK,  32'h5555_aaaa);
    send_cmd(K_ROT_FWD,    $urandom);
    send_cmd(K_ROT_BACK,   $urandom);
    send_cmd(K_ROT_BACK,   $urandom);
    send_cmd(K_DUMP,       $urandom);
    send_cmd(K_POP_FRONT,  $urandom);
    send_cmd(K_POP_BACK,   $urandom);
    send_cmd(K_POP_FRONT,  $urandom);
    send_cmd(K_POP_BACK,   $urandom);
    send_cmd(K_POP_FRONT,  $urandom);
    send_cmd(K_POP_FRONT,  $urandom);
    send_cmd(K_POP_BACK,   $urandom);
    send_cmd(K_ROT_FWD,    $urandom);
    send_cmd(K_ROT_BACK,   $urandom);
    send_cmd(K_DUMP,       $urandom);
    send_cmd(K_PUSH_FRONT, 32'h0000_0001);
    send_cmd(K_CLEAR,      $urandom);
    send_cmd(K_DUMP,       $urandom);

    // Random part. The phase changes every few dozen items so the deque swings
    // between full (pushes refused) and empty (pops refused), with dumps and
    // rotations taken at every fill level on the way.
    phase      = FILL_PHASE;
    phase_left = $urandom_range(15, 40);
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == HOLD_AT_ITEM) hold_req = 1'b1;
      if (phase_left == 0) begin
        case ($urandom_range(0, 3))
          0, 1:    phase = FILL_PHASE;
          2:       phase = DRAIN_PHASE;
          default: phase = MIXED_PHASE;
        endcase
        phase_left = $urandom_range(15, 40);
      end
      phase_left--;
      send_cmd(pick_kind(phase), draw_value());
    end
    cmd_if.valid <= 1'b0;

    // Let every owed result item arrive, then give the block time to show any extra one.
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.fail_count == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Result side: random stalls before every item, plus the single long hold-off.
  initial begin : result_taker
    int unsigned gap;
    res_t        got;
    res_if.ready <= 1'b0;
    @(posedge clk_i iff rst_ni);
    forever begin
      if (hold_req && !hold_active) begin
        hold_req    = 1'b0;
        hold_active = 1'b1;
        gap         = HOLD_CYCLES;
      end else begin
        gap = draw_gap(take_burst);
      end
      if (gap > 0) begin
        res_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      hold_active   = 1'b0;
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!res_if.valid);
      got.status      = status_e'(res_if.status);
      got.size        = res_if.size;
      got.front_value = res_if.front_value;
      got.back_value  = res_if.back_value;
      got.dump_value  = res_if.dump_value;
      got.is_empty    = res_if.is_empty;
      got.is_last     = res_if.is_last;
      sb.check_result(got);
      if ($urandom_range(0, 29) == 0) take_burst = ~take_burst;
    end
  end

  // Watchdog: ends the run if no item moves on either channel for too long.
  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("[%0t] watchdog expired with %0d result items outstanding",
             $realtime, sb.pending());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
